/* hw/rtl/mrfc_pkg.sv */
package mrfc_pkg;

    localparam int CNT_W  = 9;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [KIND_W-1:0] KIND_RD_REGS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_REGS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WR_BYTES = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EXCEPT   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_LEN_ERR = 2'd1;
    localparam logic [STAT_W-1:0] ST_CRC_ERR = 2'd2;

    localparam logic [CNT_W-1:0] LEN_RD_BASE  = 9'd5;
    localparam logic [CNT_W-1:0] LEN_WR_REGS  = 9'd8;
    localparam logic [CNT_W-1:0] LEN_WR_BYTES = 9'd7;
    localparam logic [CNT_W-1:0] LEN_EXCEPT   = 9'd5;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] exception_code;
        logic [CNT_W-1:0]  frame_length;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/mrfc_frame_check.sv */
module mrfc_frame_check #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    input  logic [1:0]             i_reply_kind,
    output logic                   o_res_valid,
    output mrfc_pkg::t_result      o_res
);
    import mrfc_pkg::*;

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_FRAME_BYTES);

    logic [15:0]       r_crc,  n_crc;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [BYTE_W-1:0] r_decl, n_decl;
    logic [KIND_W-1:0] r_kind, n_kind;

    logic [KIND_W-1:0] kind_eff;
    logic [BYTE_W-1:0] decl_eff;
    logic [15:0]       crc_eff;
    logic [CNT_W-1:0]  cnt_eff;
    logic [CNT_W-1:0]  expected;

    always_comb begin
        kind_eff = (r_cnt == '0) ? i_reply_kind : r_kind;
        decl_eff = (r_cnt == CNT_W'(2)) ? i_data_byte : r_decl;
        crc_eff  = crc16_byte(r_crc, i_data_byte);
        cnt_eff  = (r_cnt < CNT_MAX) ? r_cnt + CNT_W'(1) : r_cnt;

        case (kind_eff)
            KIND_RD_REGS:  expected = LEN_RD_BASE + {1'b0, decl_eff};
            KIND_WR_REGS:  expected = LEN_WR_REGS;
            KIND_WR_BYTES: expected = LEN_WR_BYTES;
            default:       expected = LEN_EXCEPT;
        endcase

        o_res.exception_code = decl_eff;
        o_res.frame_length   = cnt_eff;
        if (cnt_eff > MAX_LEN || cnt_eff != expected) begin
            o_res.status = ST_LEN_ERR;
        end else if (crc_eff != 16'h0000) begin
            o_res.status = ST_CRC_ERR;
        end else begin
            o_res.status = ST_OK;
        end
        o_res_valid = i_valid && i_last_byte;

        n_crc  = r_crc;
        n_cnt  = r_cnt;
        n_decl = r_decl;
        n_kind = r_kind;
        if (i_valid) begin
            if (i_last_byte) begin
                // frame done: back to idle values
                n_crc  = CRC_INIT;
                n_cnt  = '0;
                n_decl = '0;
                n_kind = '0;
            end else begin
                n_crc  = crc_eff;
                n_cnt  = cnt_eff;
                n_decl = decl_eff;
                n_kind = kind_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_cnt  <= '0;
            r_decl <= '0;
            r_kind <= '0;
        end else begin
            r_crc  <= n_crc;
            r_cnt  <= n_cnt;
            r_decl <= n_decl;
            r_kind <= n_kind;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last_byte) |=> (r_cnt == '0 && r_crc == CRC_INIT))
        else $error("state not cleared after final byte");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.status == ST_OK || o_res.status == ST_LEN_ERR ||
                         o_res.status == ST_CRC_ERR))
        else $error("bad status code");
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |=> $stable(r_cnt))
        else $error("counter moved without an item");
`endif

endmodule

/* hw/rtl/mrfc_out_buf.sv */
module mrfc_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mrfc_pkg::t_result   i_res,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_ready,
    output mrfc_pkg::t_result   o_res
);
    import mrfc_pkg::*;

    t_result     r_mem [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count;
    logic        pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (pop)    r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || pop)
        else $error("push into full result buffer");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("pointers disagree with count");
`endif

endmodule

/* hw/rtl/modbus_reply_frame_checker_core.sv */
// A final byte is registered at the input, then its result is registered in the buffer.
// Throughput: one byte per cycle; the input register advances each cycle unless a
// final byte finds the two-entry result buffer full.
// Reset: i_rst_n is synchronous, active low; it clears the frame state (CRC to 0xFFFF)
// and empties the input register and the result buffer.
module modbus_reply_frame_checker_core #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic [1:0] i_reply_kind,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_exception_code,
    output logic [8:0] o_frame_length
);
    import mrfc_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic [KIND_W-1:0] r_in_kind;

    logic    in_adv;
    logic    buf_full;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // hold a final byte until the result buffer has room
    assign in_adv     = r_in_valid && (!r_in_last || !buf_full);
    assign o_in_ready = !r_in_valid || in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
            r_in_kind <= i_reply_kind;
        end
    end

    mrfc_frame_check #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_adv),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .i_reply_kind (r_in_kind),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    mrfc_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_status         = out_res.status;
    assign o_exception_code = out_res.exception_code;
    assign o_frame_length   = out_res.frame_length;

endmodule

/* test/testbench.sv */
module testbench;
    import mrfc_pkg::*;

    localparam int FRAME_LIMIT = 256;
    localparam int RANDOM_ITEMS = 175;
    localparam int LONG_HOLD_CYCLES = 400;

    localparam int CRC_NONE = 0;
    localparam int CRC_GOOD = 1;
    localparam int CRC_BAD  = 2;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [KIND_W-1:0] kind;
        logic              drain;
    } t_frame_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_data_byte = '0;
    logic              i_last_byte = 1'b0;
    logic [1:0]        i_reply_kind = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [1:0]        o_status;
    logic [7:0]        o_exception_code;
    logic [8:0]        o_frame_length;

    t_frame_item       rx_byte_q[$];
    logic [7:0]        frame_buf[$];
    t_result           reply_status_q[$];

    // running view of the frame in progress
    logic [15:0]       crc_run = CRC_INIT;
    logic [CNT_W-1:0]  bytes_in_frame = '0;
    logic [7:0]        count_field = '0;
    logic [KIND_W-1:0] kind_seen = '0;

    t_frame_item       cur_item;
    t_result           got_reply;
    t_result           want_reply;
    int                total_items = 0;
    int                bytes_sent = 0;
    int                mismatch_cnt = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;

    modbus_reply_frame_checker_core #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_reply_kind    (i_reply_kind),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_exception_code(o_exception_code),
        .o_frame_length  (o_frame_length)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (acc[0]) acc = (acc >> 1) ^ CRC_POLY;
            else acc = acc >> 1;
        end
        return acc;
    endfunction

    function automatic int idle_phase();
        if (total_items == 0) return 0;
        return (bytes_sent * 3) / total_items;
    endfunction

    function automatic int send_idle_pct();
        case (idle_phase())
            0: return 38;
            1: return 86;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_phase())
            0: return 86;
            1: return 38;
            default: return 0;
        endcase
    endfunction

    task automatic track_frame_byte(input t_frame_item it);
        logic [CNT_W-1:0] want_len;
        t_result          res;
        if (bytes_in_frame == 0) kind_seen = it.kind;
        if (bytes_in_frame == 2) count_field = it.data;
        crc_run = modbus_crc_step(crc_run, it.data);
        if (bytes_in_frame != CNT_MAX) bytes_in_frame = bytes_in_frame + 1'b1;
        if (it.last) begin
            case (kind_seen)
                KIND_RD_REGS:  want_len = LEN_RD_BASE + {1'b0, count_field};
                KIND_WR_REGS:  want_len = LEN_WR_REGS;
                KIND_WR_BYTES: want_len = LEN_WR_BYTES;
                default:       want_len = LEN_EXCEPT;
            endcase
            if (bytes_in_frame > FRAME_LIMIT || bytes_in_frame != want_len)
                res.status = ST_LEN_ERR;
            else if (crc_run != 16'h0000)
                res.status = ST_CRC_ERR;
            else
                res.status = ST_OK;
            res.exception_code = count_field;
            res.frame_length = bytes_in_frame;
            reply_status_q.push_back(res);
            crc_run = CRC_INIT;
            bytes_in_frame = '0;
            count_field = '0;
            kind_seen = '0;
        end
    endtask

    // append CRC as asked and move frame_buf into the byte queue
    task automatic queue_frame(input logic [1:0] kind, input int crc_mode, input bit drain);
        logic [15:0] crc;
        t_frame_item it;
        crc = CRC_INIT;
        foreach (frame_buf[i]) crc = modbus_crc_step(crc, frame_buf[i]);
        if (crc_mode == CRC_BAD) crc = crc ^ (16'd1 << $urandom_range(15));
        if (crc_mode != CRC_NONE) begin
            frame_buf.push_back(crc[7:0]);
            frame_buf.push_back(crc[15:8]);
        end
        foreach (frame_buf[i]) begin
            it.data = frame_buf[i];
            it.last = (i == frame_buf.size() - 1);
            it.kind = (i == 0) ? kind : 2'($urandom_range(3));
            it.drain = drain && (i == 0);
            rx_byte_q.push_back(it);
        end
        frame_buf.delete();
    endtask

    task automatic build_reply(input logic [1:0] kind, input int rd_count);
        int body_len;
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(8'($urandom));
        case (kind)
            KIND_RD_REGS: begin
                frame_buf.push_back(8'(rd_count));
                body_len = rd_count;
            end
            KIND_WR_REGS:  body_len = 4;
            KIND_WR_BYTES: body_len = 3;
            default:       body_len = 1;
        endcase
        repeat (body_len) frame_buf.push_back(8'($urandom));
    endtask

    task automatic fill_byte_frame(input logic [7:0] value, input int len);
        repeat (len) frame_buf.push_back(value);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                track_frame_byte(cur_item);
                bytes_sent <= bytes_sent + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (rx_byte_q.size() != 0
                        && !(rx_byte_q[0].drain && reply_status_q.size() != 0)
                        && $urandom_range(99) >= send_idle_pct()) begin
                    cur_item = rx_byte_q.pop_front();
                    i_data_byte <= cur_item.data;
                    i_last_byte <= cur_item.last;
                    i_reply_kind <= cur_item.kind;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off among the random frames so the result buffer fills
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && total_items != 0 && bytes_sent >= (total_items * 9) / 10) begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_reply = '{o_status, o_exception_code, o_frame_length};
                if (reply_status_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result: status %0d code %02h length %0d",
                             $time, o_status, o_exception_code, o_frame_length);
                end else begin
                    want_reply = reply_status_q.pop_front();
                    if (got_reply !== want_reply) begin
                        mismatch_cnt++;
                        $display({"%0t: expected status %0d code %02h length %0d, ",
                                  "got status %0d code %02h length %0d"}, $time,
                                 want_reply.status, want_reply.exception_code,
                                 want_reply.frame_length, got_reply.status,
                                 got_reply.exception_code, got_reply.frame_length);
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct());
        end
    end

    initial begin
        int dir_items;
        int pick;
        int rd_count;
        logic [1:0] kind;
        int crc_mode;

        // directed frames
        build_reply(KIND_RD_REGS, 0);  queue_frame(KIND_RD_REGS, CRC_GOOD, 1'b0);
        build_reply(KIND_RD_REGS, 4);  queue_frame(KIND_RD_REGS, CRC_GOOD, 1'b0);
        build_reply(KIND_WR_REGS, 0);  queue_frame(KIND_WR_REGS, CRC_GOOD, 1'b0);
        build_reply(KIND_WR_BYTES, 0); queue_frame(KIND_WR_BYTES, CRC_GOOD, 1'b0);
        build_reply(KIND_EXCEPT, 0);   queue_frame(KIND_EXCEPT, CRC_GOOD, 1'b0);
        fill_byte_frame(8'h00, 3);     queue_frame(KIND_EXCEPT, CRC_GOOD, 1'b0);
        fill_byte_frame(8'hFF, 3);     queue_frame(KIND_EXCEPT, CRC_GOOD, 1'b0);
        // bad CRC alone, then bad length with bad CRC
        build_reply(KIND_WR_REGS, 0);  queue_frame(KIND_WR_REGS, CRC_BAD, 1'b0);
        fill_byte_frame(8'h5A, 6);     queue_frame(KIND_WR_BYTES, CRC_BAD, 1'b0);
        // short frames
        fill_byte_frame(8'hFF, 1);     queue_frame(KIND_EXCEPT, CRC_NONE, 1'b0);
        fill_byte_frame(8'h01, 2);     queue_frame(KIND_RD_REGS, CRC_NONE, 1'b0);
        // frame size limit: exactly at and just past
        build_reply(KIND_RD_REGS, FRAME_LIMIT - 5); queue_frame(KIND_RD_REGS, CRC_GOOD, 1'b0);
        build_reply(KIND_RD_REGS, FRAME_LIMIT - 4); queue_frame(KIND_RD_REGS, CRC_GOOD, 1'b0);
        dir_items = rx_byte_q.size();

        // random frames; the first one waits for every result to drain
        while (rx_byte_q.size() < dir_items + RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            kind = 2'($urandom_range(3));
            rd_count = ($urandom_range(99) < 2) ? $urandom_range(255) : $urandom_range(16);
            if (pick < 12) begin
                repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
                crc_mode = $urandom_range(CRC_BAD);
            end else begin
                build_reply(kind, rd_count);
                crc_mode = ($urandom_range(99) < 85) ? CRC_GOOD : CRC_BAD;
                // broken length: drop or add a byte before the CRC is computed and appended
                if (pick < 20) begin
                    if ($urandom_range(1) == 0) void'(frame_buf.pop_back());
                    else frame_buf.push_back(8'($urandom));
                end
            end
            queue_frame(kind, crc_mode,
                        rx_byte_q.size() == dir_items || $urandom_range(99) < 3);
        end
        total_items = rx_byte_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_sent != total_items) @(posedge i_clk);
        while (reply_status_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
